@@ src/jemm_pkg.sv @@
// Package for the jitter EMA migration monitor: field widths, fixed constants,
// configuration register indexes and the derived widths of the shared datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package jemm_pkg;

    // Field widths of the channels and of the configuration registers.
    localparam int JIT_W   = 8;
    localparam int THR_W   = 8;
    localparam int WGT_W   = 7;
    localparam int SCORE_W = 7;
    localparam int CNTR_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0] THR_RESET = 8'd5;
    localparam logic [WGT_W-1:0] WGT_RESET = 7'd30;

    // Input operation codes.
    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_INFERENCE = 1'b1;

    // Smoothing scale of the moving average.
    localparam int SMOOTH_SCALE = 100;

    // Stability score constants.
    localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;
    localparam logic [SCORE_W-1:0] SCORE_LOW = 7'd30;
    localparam int PEN_SHIFT = 2;   // penalty of five is (d << 2) + d
    localparam int PEN_W     = JIT_W + 3;

    // Recovery score*95/100 as a multiply by 95*ceil(2^19/100) and a shift by 19.
    // Exact for every 7-bit score.
    localparam int REC_SHIFT = 19;
    localparam int REC_W     = 19;
    localparam logic [REC_W-1:0] REC_MUL = 19'd498085;

    // Event rate test: rate >= 21 percent holds exactly when 100*high >= 21*infer.
    localparam int INF_MIN  = 10;
    localparam int RATE_NUM = 100;
    localparam int RATE_DEN = 21;
    localparam int RATE_W   = CNTR_W + 9;

    // Derived widths of the iterative multiplier and divider.
    localparam int SW_W  = $clog2(SMOOTH_SCALE + 1);
    localparam int MPW   = (SW_W > SCORE_W) ? SW_W : SCORE_W;
    localparam int AW    = $clog2(SMOOTH_SCALE * 255 + 1);
    localparam int RW    = $clog2(SMOOTH_SCALE);
    localparam int ACC_W = (AW > MPW + REC_W) ? AW : MPW + REC_W;
    localparam int CNT_W = $clog2((AW > MPW) ? AW : MPW);
    localparam int ALU_W = RATE_W;

endpackage

`default_nettype wire

@@ src/jemm_alu.sv @@
// Shared add/subtract unit of the jitter EMA migration monitor.
// Depends on jemm_pkg for the datapath width.
`default_nettype none

module jemm_alu
    import jemm_pkg::*;
(
    input  wire logic [ALU_W-1:0] a,
    input  wire logic [ALU_W-1:0] b,
    input  wire logic             sub,
    output logic      [ALU_W-1:0] sum,
    output logic                  cout
);

    logic [ALU_W-1:0] b_op;
    logic [ALU_W:0]   full;

    // Subtraction is a plus the inverted b plus one; carry out means no borrow.
    assign b_op = sub ? ~b : b;
    assign full = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};
    assign sum  = full[ALU_W-1:0];
    assign cout = full[ALU_W];

endmodule

`default_nettype wire

@@ src/jitter_ema_migration_monitor_unit.sv @@
// Top level of the jitter EMA migration monitor: sequencer, state and output register.
// Depends on jemm_pkg and on the shared adder jemm_alu.
`default_nettype none

// Usage.
// The input channel (s_valid/s_ready) takes one item: s_op selects a jitter
// sample (s_jitter_percent used) or an inference-done event. Every item gives
// exactly one result item on the m_ channel: migration flag, migrate decision,
// stability score and smoothed jitter, all after this item's update.
// All arithmetic runs through one shared adder under a small sequencer, so the
// block takes one item at a time and s_ready is low while it works.
// An inference event only counts; a first (seeding) sample skips the average
// update, while a later sample runs it through the shift-add multiplier (7 steps
// per product) and the restoring divider by the smoothing scale (15 steps), both
// on the shared adder.
// Results wait in an output register; a new item is accepted while a result
// waits, but its result is held back until the receiver takes the earlier one.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once; the
// user must make them only while the block is idle: the block does not enforce it.
// aresetn is synchronous and active low: it restores the register defaults
// (threshold 5, weight 30), a score of 100, clears the average and counters.

module jitter_ema_migration_monitor_unit
    import jemm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [JIT_W-1:0]      s_jitter_percent,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_migration_flag,
    output logic                       m_migrate_now,
    output logic      [SCORE_W-1:0]    m_stability,
    output logic      [JIT_W-1:0]      m_smoothed_jitter
);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MULA = 4'd1;
    localparam logic [3:0] ST_MULB = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_CMP  = 4'd4;
    localparam logic [3:0] ST_PEN  = 4'd5;
    localparam logic [3:0] ST_SUB  = 4'd6;
    localparam logic [3:0] ST_DADD = 4'd7;
    localparam logic [3:0] ST_MULR = 4'd8;
    localparam logic [3:0] ST_RFIN = 4'd9;
    localparam logic [3:0] ST_INF  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    localparam int CMPW = (SW_W > WGT_W) ? SW_W : WGT_W;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;

    // Configuration and block state.
    logic [THR_W-1:0]   thr_reg;
    logic [WGT_W-1:0]   wgt_reg;
    logic [JIT_W-1:0]   ema_reg;
    logic               seeded_reg;
    logic [JIT_W-1:0]   last_jit_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               flag_reg;
    logic [CNTR_W-1:0]  high_cnt_reg;
    logic [CNTR_W-1:0]  inf_cnt_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic               high_inc_reg;

    // Datapath working registers.
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   mcand_reg;
    logic [MPW-1:0]     mplier_reg;
    logic [RW-1:0]      rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PEN_W-1:0]   pen_reg;

    // Output register.
    logic               m_valid_reg;
    logic               m_flag_reg;
    logic               m_migrate_reg;
    logic [SCORE_W-1:0] m_score_reg;
    logic [JIT_W-1:0]   m_ema_reg;

    // Shared adder operands.
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic               alu_sub;
    logic [ALU_W-1:0]   alu_sum;
    logic               alu_cout;

    logic               accept;
    logic               cnt_last;
    logic [SW_W-1:0]    w_eff;
    logic [SW_W-1:0]    w_rest;
    logic [RW:0]        div_trial;
    logic [AW-1:0]      div_q;
    logic               above;
    logic [SCORE_W-1:0] rec_q;
    logic               out_free;
    logic               migrate_now;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign cnt_last = (cnt_reg == '0);
    assign out_free = !m_valid_reg || m_ready;

    // Weight limited to the smoothing scale, and its complement.
    assign w_eff  = (CMPW'(wgt_reg) > CMPW'(SMOOTH_SCALE)) ?
                    SW_W'(SMOOTH_SCALE) : SW_W'(wgt_reg);
    assign w_rest = SW_W'(SMOOTH_SCALE) - w_eff;

    // One restoring division step: next dividend bit joins the remainder.
    assign div_trial = {rem_reg, acc_reg[AW-1]};
    assign div_q     = {acc_reg[AW-2:0], alu_cout};

    // Average above threshold when ema - thr leaves no borrow and is non-zero.
    assign above = alu_cout && (alu_sum[JIT_W-1:0] != '0);
    assign rec_q = acc_reg[REC_SHIFT +: SCORE_W];

    // Decision from the raw sample, the score and the event rate.
    assign migrate_now = (last_jit_reg > thr_reg) || (score_reg < SCORE_LOW) ||
                         ((inf_cnt_reg > CNTR_W'(INF_MIN)) && !rate_reg[RATE_W-1]);

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_MULA, ST_MULB, ST_MULR: begin
                alu_a = ALU_W'(acc_reg);
                alu_b = mplier_reg[0] ? ALU_W'(mcand_reg) : '0;
            end
            ST_DIV: begin
                alu_a   = ALU_W'(div_trial);
                alu_b   = ALU_W'(SMOOTH_SCALE);
                alu_sub = 1'b1;
            end
            ST_CMP: begin
                alu_a   = ALU_W'(ema_reg);
                alu_b   = ALU_W'(thr_reg);
                alu_sub = 1'b1;
            end
            ST_PEN: begin
                alu_a = ALU_W'({pen_reg, {PEN_SHIFT{1'b0}}});
                alu_b = ALU_W'(pen_reg);
            end
            ST_SUB: begin
                alu_a   = ALU_W'(score_reg);
                alu_b   = ALU_W'(pen_reg);
                alu_sub = 1'b1;
            end
            ST_DADD: begin
                alu_a = rate_reg;
                alu_b = ALU_W'(RATE_NUM);
            end
            ST_INF: begin
                alu_a   = rate_reg;
                alu_b   = ALU_W'(RATE_DEN);
                alu_sub = 1'b1;
            end
            ST_RFIN: begin
                alu_a = ALU_W'(rec_q);
                alu_b = ALU_W'(1);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    jemm_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .cout (alu_cout)
    );

    // Sequencer transitions.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_INFERENCE) begin
                        state_next = ST_INF;
                    end else if (!seeded_reg) begin
                        state_next = ST_CMP;
                    end else begin
                        state_next = ST_MULA;
                    end
                end
            end
            ST_MULA: if (cnt_last) state_next = ST_MULB;
            ST_MULB: if (cnt_last) state_next = ST_DIV;
            ST_DIV:  if (cnt_last) state_next = ST_CMP;
            ST_CMP:  state_next = above ? ST_PEN : ST_MULR;
            ST_PEN:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_DADD;
            ST_DADD: state_next = ST_DONE;
            ST_MULR: if (cnt_last) state_next = ST_RFIN;
            ST_RFIN: state_next = ST_DONE;
            ST_INF:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and block state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THR_RESET;
            wgt_reg      <= WGT_RESET;
            ema_reg      <= '0;
            seeded_reg   <= 1'b0;
            last_jit_reg <= '0;
            score_reg    <= SCORE_MAX;
            flag_reg     <= 1'b0;
            high_cnt_reg <= '0;
            inf_cnt_reg  <= '0;
            rate_reg     <= '0;
            high_inc_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                    CFG_WEIGHT:    wgt_reg <= cfg_wdata[WGT_W-1:0];
                    default:       ;
                endcase
            end

            // The first sample seeds the average directly.
            if (accept && (s_op == OP_SAMPLE)) begin
                last_jit_reg <= s_jitter_percent;
                if (!seeded_reg) begin
                    ema_reg    <= s_jitter_percent;
                    seeded_reg <= 1'b1;
                end
            end

            // Quotient of the final division step is the new average.
            if ((state_reg == ST_DIV) && cnt_last) begin
                ema_reg <= div_q[JIT_W-1:0];
            end

            if (state_reg == ST_CMP) begin
                high_inc_reg <= (high_cnt_reg != '1);
            end

            // Penalty applied with a floor at zero.
            if (state_reg == ST_SUB) begin
                score_reg <= alu_cout ? alu_sum[SCORE_W-1:0] : '0;
                flag_reg  <= 1'b1;
            end

            // High event: bump the counter and the rate balance unless saturated.
            if ((state_reg == ST_DADD) && high_inc_reg) begin
                high_cnt_reg <= high_cnt_reg + CNTR_W'(1);
                rate_reg     <= alu_sum;
            end

            // Recovery step, plus one while below the maximum.
            if (state_reg == ST_RFIN) begin
                score_reg <= (rec_q < SCORE_MAX) ? alu_sum[SCORE_W-1:0] : rec_q;
                flag_reg  <= 1'b0;
            end

            // Inference event only counts.
            if ((state_reg == ST_INF) && (inf_cnt_reg != '1)) begin
                inf_cnt_reg <= inf_cnt_reg + CNTR_W'(1);
                rate_reg    <= alu_sum;
            end

            // Output register handshake.
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Multiplier, divider and penalty working registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                acc_reg    <= '0;
                mcand_reg  <= ACC_W'(s_jitter_percent);
                mplier_reg <= MPW'(w_eff);
                cnt_reg    <= CNT_W'(MPW - 1);
            end
            ST_MULA, ST_MULB, ST_MULR: begin
                acc_reg    <= alu_sum[ACC_W-1:0];
                mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - CNT_W'(1);
                if (cnt_last && (state_reg == ST_MULA)) begin
                    mcand_reg  <= ACC_W'(ema_reg);
                    mplier_reg <= MPW'(w_rest);
                    cnt_reg    <= CNT_W'(MPW - 1);
                end else if (cnt_last && (state_reg == ST_MULB)) begin
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(AW - 1);
                end
            end
            ST_DIV: begin
                rem_reg <= alu_cout ? alu_sum[RW-1:0] : div_trial[RW-1:0];
                acc_reg <= ACC_W'(div_q);
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_CMP: begin
                pen_reg    <= PEN_W'(alu_sum[JIT_W-1:0]);
                acc_reg    <= '0;
                mcand_reg  <= ACC_W'(REC_MUL);
                mplier_reg <= MPW'(score_reg);
                cnt_reg    <= CNT_W'(MPW - 1);
            end
            ST_PEN: begin
                pen_reg <= alu_sum[PEN_W-1:0];
            end
            default: ;
        endcase
    end

    // Result captured once the output register is free.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_flag_reg    <= flag_reg;
            m_migrate_reg <= migrate_now;
            m_score_reg   <= score_reg;
            m_ema_reg     <= ema_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_migration_flag  = m_flag_reg;
    assign m_migrate_now     = m_migrate_reg;
    assign m_stability       = m_score_reg;
    assign m_smoothed_jitter = m_ema_reg;

endmodule

`default_nettype wire
